// ===== rtl/bfec_pkg.sv =====
// Shared opcode and fault codes for the brainfuck execution core.
package bfec_pkg;

  typedef enum logic [3:0] {
    CMD_RIGHT = 4'd0,
    CMD_LEFT  = 4'd1,
    CMD_INC   = 4'd2,
    CMD_DEC   = 4'd3,
    CMD_IN    = 4'd4,
    CMD_OUT   = 4'd5,
    CMD_OPEN  = 4'd6,
    CMD_CLOSE = 4'd7,
    CMD_NOP   = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    FLT_NONE      = 2'd0,
    FLT_OVERFLOW  = 2'd1,
    FLT_UNDERFLOW = 2'd2
  } fault_t;

  localparam int unsigned CMD_W     = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PLEN_W    = 16;
  localparam int unsigned OPC_W     = 16;
  localparam int unsigned IN_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 32;

endpackage

// ===== rtl/bfec_tape.sv =====
// Tape cell memory with per-cell valid bits and write-to-read forwarding.
module bfec_tape #(
  parameter int unsigned TAPE_CELLS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [$clog2(TAPE_CELLS)-1:0] rd_addr,
  input  logic                          wr_en,
  input  logic [$clog2(TAPE_CELLS)-1:0] wr_addr,
  input  logic [7:0]                    wr_data,
  output logic [7:0]                    rd_data
);
  import bfec_pkg::*;

  logic [BYTE_W-1:0]  mem [TAPE_CELLS];
  logic [TAPE_CELLS-1:0] vld_r;
  logic [BYTE_W-1:0]  q_r;
  logic               q_vld_r;
  logic               fwd_r;
  logic [BYTE_W-1:0]  fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
        fwd_r   <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : (q_vld_r ? q_r : '0);

endmodule

// ===== rtl/bfec_stack.sv =====
// Loop-return stack memory with write-to-read forwarding.
module bfec_stack #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned PC_WIDTH    = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
  input  logic                           wr_en,
  input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
  input  logic [PC_WIDTH-1:0]            wr_data,
  output logic [PC_WIDTH-1:0]            rd_data
);
  import bfec_pkg::*;

  logic [PC_WIDTH-1:0] mem [STACK_DEPTH];
  logic [PC_WIDTH-1:0] q_r;
  logic                fwd_r;
  logic [PC_WIDTH-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

// ===== rtl/brainfuck_execution_core.sv =====
// Brainfuck execution core top level: fetch stage, execute stage and result register.
//
//  channel | dir | fields (low bit up)
//  in_     | in  | tdata: cmd[3:0], in_byte[11:4], zero[15:12]
//  out_    | out | tdata: next_pc[15:0], out_valid[16], out_byte[24:17], halted[25],
//          |     |        fault[27:26], zero[31:28]
//  cfg_    | in  | wr_data: program_length[15:0]
//
// One instruction per cycle sustained while out_ is not stalled.
// The transfer reads the tape cell and stack top; the execute stage executes and writes back.
// Tape cells reset to zero through valid flops; no clearing pass, items accepted right after reset.
// A stalled out_ channel holds one result plus one item in the execute stage, then drops in_tready.
module brainfuck_execution_core #(
  parameter int unsigned TAPE_CELLS  = 64,
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned PC_WIDTH    = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bfec_pkg::IN_DATA_W-1:0]  in_tdata,   // cmd, in_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bfec_pkg::OUT_DATA_W-1:0] out_tdata,  // next_pc, out_valid, out_byte, halted, fault
  input  logic                         cfg_wr_en,
  input  logic [bfec_pkg::PLEN_W-1:0]  cfg_wr_data
);
  import bfec_pkg::*;

  localparam int unsigned CPW = $clog2(TAPE_CELLS);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned DW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned TW  = PC_WIDTH + 1;
  localparam int unsigned CW  = (TW > PLEN_W) ? TW : PLEN_W;

  logic [PLEN_W-1:0]   prog_len_r;
  logic [CPW-1:0]      cp_r, cp_nxt;
  logic [PC_WIDTH-1:0] pc_r, pc_nxt;
  logic [DW-1:0]       depth_r, depth_nxt, depth_m1;
  logic                stopped_r, stopped_nxt;
  fault_t              fault_r, fault_nxt;

  logic                s1_vld_r;
  logic [CMD_W-1:0]    s1_cmd_r;
  logic [BYTE_W-1:0]   s1_byte_r;

  logic                out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                in_xfer, exec_go;
  logic [BYTE_W-1:0]   tape_q;
  logic [PC_WIDTH-1:0] stk_top;
  logic                tape_we, stk_we;
  logic [BYTE_W-1:0]   tape_wd;
  logic [TW-1:0]       target;
  logic                faulted;
  logic                o_valid;
  logic [BYTE_W-1:0]   o_byte;
  logic [CW-1:0]       pc_ext;

  assign exec_go   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || exec_go;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    cp_nxt      = cp_r;
    pc_nxt      = pc_r;
    depth_nxt   = depth_r;
    stopped_nxt = stopped_r;
    fault_nxt   = fault_r;
    tape_we     = 1'b0;
    tape_wd     = tape_q;
    stk_we      = 1'b0;
    o_valid     = 1'b0;
    o_byte      = '0;
    faulted     = 1'b0;
    target      = TW'(pc_r) + TW'(1);
    if (exec_go && !stopped_r) begin
      unique case (cmd_t'(s1_cmd_r))
        CMD_RIGHT: cp_nxt = (cp_r == CPW'(TAPE_CELLS - 1)) ? '0 : cp_r + CPW'(1);
        CMD_LEFT:  cp_nxt = (cp_r == '0) ? CPW'(TAPE_CELLS - 1) : cp_r - CPW'(1);
        CMD_INC: begin
          tape_we = 1'b1;
          tape_wd = tape_q + BYTE_W'(1);
        end
        CMD_DEC: begin
          tape_we = 1'b1;
          tape_wd = tape_q - BYTE_W'(1);
        end
        CMD_IN: begin
          tape_we = 1'b1;
          tape_wd = s1_byte_r;
        end
        CMD_OUT: begin
          o_valid = 1'b1;
          o_byte  = tape_q;
        end
        CMD_OPEN: begin
          if (depth_r >= DW'(STACK_DEPTH)) begin
            faulted   = 1'b1;
            fault_nxt = FLT_OVERFLOW;
          end else begin
            stk_we    = 1'b1;
            depth_nxt = depth_r + DW'(1);
          end
        end
        CMD_CLOSE: begin
          if (depth_r == '0) begin
            faulted   = 1'b1;
            fault_nxt = FLT_UNDERFLOW;
          end else if (tape_q != '0) begin
            target = TW'(stk_top);
          end else begin
            depth_nxt = depth_r - DW'(1);
          end
        end
        default: ;
      endcase
      if (faulted) begin
        stopped_nxt = 1'b1;
      end else begin
        pc_nxt = target[PC_WIDTH-1:0];
        if (CW'(target) > CW'(prog_len_r)) begin
          stopped_nxt = 1'b1;
        end
      end
    end
    depth_m1 = depth_nxt - DW'(1);
    pc_ext   = CW'(pc_nxt);
  end

  bfec_tape #(
    .TAPE_CELLS(TAPE_CELLS)
  ) u_tape (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_xfer),
    .rd_addr(cp_nxt),
    .wr_en  (tape_we),
    .wr_addr(cp_r),
    .wr_data(tape_wd),
    .rd_data(tape_q)
  );

  bfec_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .PC_WIDTH   (PC_WIDTH)
  ) u_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_xfer),
    .rd_addr(depth_m1[SAW-1:0]),
    .wr_en  (stk_we),
    .wr_addr(depth_r[SAW-1:0]),
    .wr_data(target[PC_WIDTH-1:0]),
    .rd_data(stk_top)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
      cp_r       <= '0;
      pc_r       <= '0;
      depth_r    <= '0;
      stopped_r  <= 1'b0;
      fault_r    <= FLT_NONE;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        prog_len_r <= cfg_wr_data;
      end
      cp_r      <= cp_nxt;
      pc_r      <= pc_nxt;
      depth_r   <= depth_nxt;
      stopped_r <= stopped_nxt;
      fault_r   <= fault_nxt;
      if (in_xfer) begin
        s1_vld_r <= 1'b1;
      end else if (exec_go) begin
        s1_vld_r <= 1'b0;
      end
      if (exec_go) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r  <= in_tdata[CMD_W-1:0];
      s1_byte_r <= in_tdata[CMD_W +: BYTE_W];
    end
    if (exec_go) begin
      out_data_r <= {4'b0000, fault_nxt, stopped_nxt, o_byte, o_valid, pc_ext[OPC_W-1:0]};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_vld_r && out_vld_r && !out_tready))
    else $error("in_tready low without a stalled result");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("halt cleared");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("loop stack depth out of range");

  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r != FLT_NONE) |-> stopped_r)
    else $error("fault without halt");

endmodule

// ===== tb/sv/bfec_checker.sv =====
// Checker for the brainfuck execution core: predicts each step and compares the out_ channel.
module bfec_checker #(
  parameter int unsigned TAPE_CELLS  = 64,
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bfec_pkg::IN_DATA_W-1:0]  in_tdata,    // cmd, in_byte
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bfec_pkg::OUT_DATA_W-1:0] out_tdata,   // next_pc, out_valid, out_byte, halted, fault
  input  logic                            cfg_wr_en,
  input  logic [bfec_pkg::PLEN_W-1:0]     cfg_wr_data,
  output int                              fail_count,
  output int                              results_owed,
  output logic [bfec_pkg::OPC_W-1:0]      model_pc,
  output int                              model_depth,
  output logic                            model_halted
);
  import bfec_pkg::*;

  typedef struct packed {
    logic [3:0]        pad;
    fault_t            fault;
    logic              halted;
    logic [BYTE_W-1:0] char_out;
    logic              emitted;
    logic [OPC_W-1:0]  next_pc;
  } step_result_t;

  logic [BYTE_W-1:0] tape [TAPE_CELLS];
  logic [OPC_W-1:0]  return_stack [STACK_DEPTH];
  int                head;
  int                depth;
  logic [OPC_W-1:0]  pc;
  logic [PLEN_W-1:0] prog_len;
  logic              stopped;
  fault_t            fault_code;
  step_result_t      exec_results [$];

  function automatic step_result_t execute(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data);
    logic [OPC_W:0] target;
    step_result_t   r;
    r = '0;
    if (!stopped) begin
      target = {1'b0, pc} + 1'b1;
      case (cmd)
        CMD_RIGHT: head = (head == TAPE_CELLS - 1) ? 0 : head + 1;
        CMD_LEFT:  head = (head == 0) ? TAPE_CELLS - 1 : head - 1;
        CMD_INC:   tape[head] = tape[head] + 1'b1;
        CMD_DEC:   tape[head] = tape[head] - 1'b1;
        CMD_IN:    tape[head] = data;
        CMD_OUT: begin
          r.emitted  = 1'b1;
          r.char_out = tape[head];
        end
        CMD_OPEN: begin
          if (depth >= STACK_DEPTH) begin
            stopped    = 1'b1;
            fault_code = FLT_OVERFLOW;
          end else begin
            return_stack[depth] = target[OPC_W-1:0];
            depth++;
          end
        end
        CMD_CLOSE: begin
          if (depth == 0) begin
            stopped    = 1'b1;
            fault_code = FLT_UNDERFLOW;
          end else if (tape[head] != '0) begin
            target = {1'b0, return_stack[depth-1]};
          end else begin
            depth--;
          end
        end
        default: ;
      endcase
      if (!stopped) begin
        pc = target[OPC_W-1:0];
        if (target > {1'b0, prog_len}) stopped = 1'b1;
      end
    end
    r.next_pc = pc;
    r.halted  = stopped;
    r.fault   = fault_code;
    return r;
  endfunction

  always @(posedge clk) begin
    step_result_t got;
    step_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < TAPE_CELLS; i++) tape[i] = '0;
      head       = 0;
      depth      = 0;
      pc         = '0;
      prog_len   = '0;
      stopped    = 1'b0;
      fault_code = FLT_NONE;
      fail_count = 0;
      exec_results.delete();
    end else begin
      if (cfg_wr_en) prog_len = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        got = step_result_t'(out_tdata);
        if (exec_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected out_ transfer %h with no step outstanding", out_tdata);
        end else begin
          want = exec_results.pop_front();
          if (got.next_pc !== want.next_pc || got.emitted !== want.emitted ||
              got.char_out !== want.char_out || got.halted !== want.halted ||
              got.fault !== want.fault) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"step mismatch: want pc %h emit %b char %h halt %b fault %0d,",
                        " got pc %h emit %b char %h halt %b fault %0d"},
                       want.next_pc, want.emitted, want.char_out, want.halted, want.fault,
                       got.next_pc, got.emitted, got.char_out, got.halted, got.fault);
          end
        end
      end
      if (in_tvalid && in_tready)
        exec_results.push_back(execute(in_tdata[CMD_W-1:0], in_tdata[CMD_W+BYTE_W-1:CMD_W]));
    end
    results_owed = exec_results.size();
    model_pc     = pc;
    model_depth  = depth;
    model_halted = stopped;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top-level testbench for the brainfuck execution core: clock, reset, stimulus and verdict.
module tb_top;
  import bfec_pkg::*;

  localparam int unsigned TAPE_CELLS  = 64;
  localparam int unsigned STACK_DEPTH = 1024;
  localparam int          STALL_LIMIT = 2000;
  localparam int          PHASE_ITEMS = 330;
  localparam int          NOISE_DEPTH_CAP = 48;

  typedef enum int {HALT_BY_LENGTH, HALT_BY_UNDERFLOW, HALT_BY_OVERFLOW} halt_path_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // cmd, in_byte
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // next_pc, out_valid, out_byte, halted, fault
  logic                  cfg_wr_en;
  logic [PLEN_W-1:0]     cfg_wr_data;

  int               fail_count;
  int               results_owed;
  logic [OPC_W-1:0] model_pc;
  int               model_depth;
  logic             model_halted;

  logic             quiet;
  int               items_sent;
  int               stall_cycles;
  logic [CMD_W-1:0]  code_mem [0:65535];
  logic [BYTE_W-1:0] arg_mem [0:65535];
  int               code_end;

  always #5 clk = ~clk;

  brainfuck_execution_core #(
    .TAPE_CELLS (TAPE_CELLS),
    .STACK_DEPTH(STACK_DEPTH),
    .PC_WIDTH   (16)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  bfec_checker #(
    .TAPE_CELLS (TAPE_CELLS),
    .STACK_DEPTH(STACK_DEPTH)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .results_owed(results_owed),
    .model_pc    (model_pc),
    .model_depth (model_depth),
    .model_halted(model_halted)
  );

  always @(negedge clk) begin
    out_tready <= rst_n && (quiet || $urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  task automatic send(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
    while (!quiet && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, b, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic set_length(input logic [PLEN_W-1:0] len);
    in_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void pick_plain(output logic [CMD_W-1:0] c, output logic [BYTE_W-1:0] b);
    case ($urandom_range(0, 6))
      0:       c = CMD_RIGHT;
      1:       c = CMD_LEFT;
      2:       c = CMD_INC;
      3:       c = CMD_DEC;
      4:       c = CMD_IN;
      5:       c = CMD_OUT;
      default: c = 4'(CMD_NOP + $urandom_range(0, 7));
    endcase
    b = 8'($urandom_range(0, 255));
  endfunction

  function automatic void put(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
    code_mem[16'(code_end)] = c;
    arg_mem[16'(code_end)]  = b;
    code_end++;
  endfunction

  // loop body never touches the counter cell and leaves the pointer where it found it
  function automatic void put_body(input bit allow_inner);
    logic [CMD_W-1:0] side_op;
    case ($urandom_range(0, 3))
      0: side_op = CMD_INC;
      1: side_op = CMD_DEC;
      2: side_op = CMD_IN;
      default: side_op = CMD_OUT;
    endcase
    case ($urandom_range(0, 4))
      0: put(CMD_OUT, 8'($urandom_range(0, 255)));
      1: put(4'(CMD_NOP + $urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      2: begin
        put(CMD_RIGHT, 8'h00);
        put(side_op, 8'($urandom_range(0, 255)));
        put(CMD_LEFT, 8'h00);
      end
      3: begin
        put(CMD_LEFT, 8'h00);
        put(side_op, 8'($urandom_range(0, 255)));
        put(CMD_RIGHT, 8'h00);
      end
      default: begin
        if (allow_inner) begin
          put(CMD_RIGHT, 8'h00);
          put(CMD_IN, 8'($urandom_range(1, 3)));
          put(CMD_OPEN, 8'h00);
          put(CMD_DEC, 8'h00);
          put(CMD_OUT, 8'h00);
          put(CMD_CLOSE, 8'h00);
          put(CMD_LEFT, 8'h00);
        end else begin
          put(CMD_OUT, 8'h00);
        end
      end
    endcase
  endfunction

  function automatic void put_loop();
    put(CMD_IN, 8'($urandom_range(1, 4)));
    put(CMD_OPEN, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 2)) put_body(1'b1);
    put(CMD_DEC, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 2)) put_body(1'b1);
    put(CMD_CLOSE, 8'($urandom_range(0, 255)));
  endfunction

  // lay a short program at the current pc and feed it by the predicted fetch address
  task automatic run_program();
    int                base;
    int                guard;
    logic [CMD_W-1:0]  c;
    logic [BYTE_W-1:0] b;
    base     = int'(model_pc);
    code_end = base;
    repeat ($urandom_range(0, 3)) begin
      pick_plain(c, b);
      put(c, b);
    end
    repeat ($urandom_range(1, 2)) put_loop();
    guard = 0;
    while (!model_halted && int'(model_pc) >= base && int'(model_pc) < code_end &&
           guard < 1000) begin
      send(code_mem[model_pc], arg_mem[model_pc]);
      guard++;
    end
  endtask

  task automatic run_noise();
    logic [CMD_W-1:0]  c;
    logic [BYTE_W-1:0] b;
    repeat ($urandom_range(1, 8)) begin
      c = 4'($urandom_range(0, 15));
      b = 8'($urandom_range(0, 255));
      if ((c == CMD_CLOSE && model_depth == 0) ||
          (c == CMD_OPEN && model_depth >= NOISE_DEPTH_CAP))
        c = CMD_NOP;
      send(c, b);
    end
  endtask

  initial begin
    int                phase_start;
    halt_path_t        halt_path;
    logic [CMD_W-1:0]  c;
    logic [BYTE_W-1:0] b;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    quiet       = 1'b0;
    items_sent  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_length(16'hFFFF);
    send(CMD_LEFT,  8'h00);
    send(CMD_RIGHT, 8'h00);
    send(CMD_DEC,   8'h00);
    send(CMD_OUT,   8'h00);
    send(CMD_INC,   8'h00);
    send(CMD_OUT,   8'h00);
    send(CMD_IN,    8'hA5);
    send(CMD_OUT,   8'h00);
    send(CMD_IN,    8'h5A);
    send(CMD_INC,   8'hFF);
    send(CMD_OUT,   8'h00);
    send(CMD_NOP,   8'h00);
    send(4'(CMD_NOP + 1), 8'hFF);
    send(4'(CMD_NOP + 7), 8'h00);
    send(4'(CMD_NOP + 4), 8'h00);
    send(CMD_IN,    8'h01);
    send(CMD_OPEN,  8'h00);
    send(CMD_CLOSE, 8'h00);
    send(CMD_IN,    8'h00);
    send(CMD_CLOSE, 8'h00);
    send(CMD_IN,    8'hFF);
    send(CMD_OUT,   8'h00);
    send(CMD_RIGHT, 8'h00);
    send(CMD_INC,   8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 1 || phase == 2)
        set_length(16'($urandom_range(4096, 65534)));
      else if (phase == 3)
        set_length(16'hFFFF);
      quiet       = (phase == 2);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) run_program();
        else run_noise();
      end
    end
    quiet = 1'b0;

    halt_path = halt_path_t'($urandom_range(0, 2));
    case (halt_path)
      HALT_BY_LENGTH: begin
        set_length(16'(model_pc + $urandom_range(0, 3)));
        while (!model_halted) begin
          pick_plain(c, b);
          send(c, b);
        end
      end
      HALT_BY_UNDERFLOW: begin
        send(CMD_IN, 8'h00);
        while (model_depth != 0 && !model_halted)
          send(CMD_CLOSE, 8'($urandom_range(0, 255)));
        send(CMD_CLOSE, 8'($urandom_range(0, 255)));
      end
      default: begin
        repeat (STACK_DEPTH - model_depth + 1) send(CMD_OPEN, 8'($urandom_range(0, 255)));
      end
    endcase

    set_length(16'h0000);
    repeat (20) send(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    in_tvalid <= 1'b0;

    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
